>>> src/iase_pkg.sv
// ============================================================================
// iase_pkg
// Types and codes shared by the insertable array search engine and its cells.
// ============================================================================
package iase_pkg;

    localparam int DATA_W    = 32;
    localparam int CNT_W     = 7;
    localparam int STATUS_W  = 3;
    localparam int CMD_W     = 2;
    localparam int MAX_DEPTH = 64;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } cell_op_t;

    // Broadcast control for every cell of the chain
    typedef struct packed {
        cell_op_t                 op;
        logic [CNT_W-1:0]         ins_idx;   // 0-based insert slot
        logic [CNT_W-1:0]         count;     // entries currently held
        logic signed [DATA_W-1:0] ins_val;   // value written at the insert slot
        logic signed [DATA_W-1:0] key;       // search key
        logic signed [DATA_W-1:0] head;      // value of cell 0, wraps on rotate
    } cell_ctl_t;

endpackage

>>> src/iase_cell.sv
// ============================================================================
// iase_cell
// One storage cell of the chain: holds one entry, shifts up on insert,
// shifts down on readout rotation, and compares against the search key.
// ============================================================================
module iase_cell #(
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  iase_pkg::cell_ctl_t           ctl,
    input  logic signed [iase_pkg::DATA_W-1:0] prev_value,
    input  logic signed [iase_pkg::DATA_W-1:0] next_value,
    output logic signed [iase_pkg::DATA_W-1:0] value_out,
    output logic                          match
);
    import iase_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic signed [DATA_W-1:0] cell_value_reg;
    logic signed [DATA_W-1:0] cell_value_next;
    logic                     in_use;

    assign in_use    = (IDX_C < ctl.count);
    assign value_out = cell_value_reg;
    assign match     = in_use && (cell_value_reg == ctl.key);

    always_comb
    begin
        cell_value_next = cell_value_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                // write the new entry at its slot, push later entries up
                if (IDX_C == ctl.ins_idx)
                    cell_value_next = ctl.ins_val;
                else if (IDX_C > ctl.ins_idx)
                    cell_value_next = prev_value;
            end
            CELL_ROTATE:
            begin
                // advance toward cell 0; the last used cell takes the head
                if (in_use)
                begin
                    if (IDX_C == ctl.count - CNT_W'(1))
                        cell_value_next = ctl.head;
                    else
                        cell_value_next = next_value;
                end
            end
            default:
            begin
                cell_value_next = cell_value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cell_value_reg <= cell_value_next;
    end

endmodule

>>> src/insertable_array_search_engine.sv
// ============================================================================
// insertable_array_search_engine
// Ordered store of signed 32-bit entries with insert, search and readout.
// ============================================================================
// The store is a chain of DEPTH cells, one entry per cell, position 1 in
// cell 0. A request is taken only while the engine is idle, then executed
// from registered copies of its fields. Insert shifts every later cell up
// at once and answers with one result. Search compares all cells against
// the key in parallel, registers the match vector, and encodes the first
// hit in the next cycle. Readout rotates the used cells toward cell 0 and
// streams cell 0 out, one entry per cycle while the output register is
// free. Each result is held in an output register; the engine takes the
// next request while the last result of the previous one still waits
// there. Command code 3 is dropped with no result. Every result carries
// the entry count and the running maximum and minimum after the request;
// the extremes read zero while the store is empty. Entries are not
// cleared at reset; only the used positions are ever read.
// ============================================================================
module insertable_array_search_engine #(
    parameter int DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [iase_pkg::CMD_W-1:0]          command,
    input  logic [iase_pkg::CNT_W-1:0]          position,
    input  logic signed [iase_pkg::DATA_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [iase_pkg::STATUS_W-1:0]       status,
    output logic [iase_pkg::CNT_W-1:0]          found_position,
    output logic signed [iase_pkg::DATA_W-1:0]  element,
    output logic                                last,
    output logic [iase_pkg::CNT_W-1:0]          entry_count,
    output logic signed [iase_pkg::DATA_W-1:0]  maximum,
    output logic signed [iase_pkg::DATA_W-1:0]  minimum
);
    import iase_pkg::*;

    localparam int               IDX_W   = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SRCH,
        S_READ
    } state_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-2:0] idx;
    } first_hit_t;

    // Two-level first-set encoder over the padded match vector: pick the
    // lowest hit inside each group of eight, then the lowest group.
    function automatic first_hit_t first_hit(input logic [MAX_DEPTH-1:0] m);
        logic [7:0]       grp_any;
        logic [2:0]       grp_idx [8];
        first_hit_t       res;
        grp_any = '0;
        res     = '0;
        for (int g = 0; g < 8; g++)
        begin
            grp_idx[g] = '0;
            for (int b = 7; b >= 0; b--)
            begin
                if (m[g*8 + b])
                begin
                    grp_any[g] = 1'b1;
                    grp_idx[g] = 3'(b);
                end
            end
        end
        for (int g = 7; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                res.found = 1'b1;
                res.idx   = {3'(g), grp_idx[g]};
            end
        end
        return res;
    endfunction

    // Control and request registers
    state_t                   state_reg, state_next;
    logic [CMD_W-1:0]         cmd_reg, cmd_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [DEPTH-1:0]         match_reg, match_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;

    // Store summary
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [DATA_W-1:0] max_reg, max_next;
    logic signed [DATA_W-1:0] min_reg, min_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [CNT_W-1:0]         fpos_reg, fpos_next;
    logic signed [DATA_W-1:0] element_reg, element_next;
    logic                     last_reg, last_next;
    logic [CNT_W-1:0]         ecount_reg, ecount_next;
    logic signed [DATA_W-1:0] maximum_reg, maximum_next;
    logic signed [DATA_W-1:0] minimum_reg, minimum_next;

    // Chain wiring
    cell_ctl_t                cell_ctl;
    cell_op_t                 cell_op;
    logic signed [DATA_W-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]         cell_match;

    // Emission of one result
    logic                     out_free;
    logic                     emit;
    logic [STATUS_W-1:0]      e_status;
    logic [CNT_W-1:0]         e_fpos;
    logic signed [DATA_W-1:0] e_element;
    logic                     e_last;

    logic                     bad_pos;
    logic                     is_full;
    logic                     rd_last;
    first_hit_t               hit;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign bad_pos   = (pos_reg == '0) ||
                       ({1'b0, pos_reg} > ({1'b0, count_reg} + (CNT_W+1)'(1)));
    assign is_full   = (count_reg >= DEPTH_C);
    assign rd_last   = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);
    assign hit       = first_hit(MAX_DEPTH'(match_reg));

    assign cell_ctl.op      = cell_op;
    assign cell_ctl.ins_idx = pos_reg - CNT_W'(1);
    assign cell_ctl.count   = count_reg;
    assign cell_ctl.ins_val = val_reg;
    assign cell_ctl.key     = val_reg;
    assign cell_ctl.head    = cell_value[0];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] prev_v;
            logic signed [DATA_W-1:0] next_v;
            if (gi == 0)
            begin : g_first
                assign prev_v = '0;
            end
            else
            begin : g_mid
                assign prev_v = cell_value[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_end
                assign next_v = cell_value[0];
            end
            else
            begin : g_inner
                assign next_v = cell_value[gi+1];
            end
            iase_cell #(
                .IDX (gi)
            ) u_cell (
                .clk        (clk),
                .ctl        (cell_ctl),
                .prev_value (prev_v),
                .next_value (next_v),
                .value_out  (cell_value[gi]),
                .match      (cell_match[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        match_next     = match_reg;
        rd_idx_next    = rd_idx_reg;
        count_next     = count_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        cell_op        = CELL_HOLD;
        emit           = 1'b0;
        e_status       = ST_OK;
        e_fpos         = '0;
        e_element      = '0;
        e_last         = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    pos_next   = position;
                    val_next   = value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (bad_pos)
                                e_status = ST_BADPOS;
                            else if (is_full)
                                e_status = ST_FULL;
                            else
                            begin
                                cell_op    = CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                                if (count_reg == '0)
                                begin
                                    max_next = val_reg;
                                    min_next = val_reg;
                                end
                                else
                                begin
                                    if (val_reg > max_reg)
                                        max_next = val_reg;
                                    if (val_reg < min_reg)
                                        min_next = val_reg;
                                end
                            end
                        end
                    end
                    CMD_SEARCH:
                    begin
                        if (count_reg == '0)
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                e_status   = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            match_next = cell_match;
                            state_next = S_SRCH;
                        end
                    end
                    CMD_READ:
                    begin
                        if (count_reg == '0)
                        begin
                            if (out_free)
                            begin
                                emit       = 1'b1;
                                e_status   = ST_EMPTY;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            rd_idx_next = '0;
                            state_next  = S_READ;
                        end
                    end
                    default:
                    begin
                        // unused code: drop the request
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SRCH:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (hit.found)
                    begin
                        e_status = ST_OK;
                        e_fpos   = {1'b0, hit.idx} + CNT_W'(1);
                    end
                    else
                        e_status = ST_MISS;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    e_element   = cell_value[0];
                    e_last      = rd_last;
                    cell_op     = CELL_ROTATE;
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                    if (rd_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        fpos_next      = fpos_reg;
        element_next   = element_reg;
        last_next      = last_reg;
        ecount_next    = ecount_reg;
        maximum_next   = maximum_reg;
        minimum_next   = minimum_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            status_next    = e_status;
            fpos_next      = e_fpos;
            element_next   = e_element;
            last_next      = e_last;
            ecount_next    = count_next;
            maximum_next   = (count_next == '0) ? '0 : max_next;
            minimum_next   = (count_next == '0) ? '0 : min_next;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            pos_reg       <= '0;
            val_reg       <= '0;
            match_reg     <= '0;
            rd_idx_reg    <= '0;
            count_reg     <= '0;
            max_reg       <= '0;
            min_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            fpos_reg      <= '0;
            element_reg   <= '0;
            last_reg      <= 1'b0;
            ecount_reg    <= '0;
            maximum_reg   <= '0;
            minimum_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            pos_reg       <= pos_next;
            val_reg       <= val_next;
            match_reg     <= match_next;
            rd_idx_reg    <= rd_idx_next;
            count_reg     <= count_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            fpos_reg      <= fpos_next;
            element_reg   <= element_next;
            last_reg      <= last_next;
            ecount_reg    <= ecount_next;
            maximum_reg   <= maximum_next;
            minimum_reg   <= minimum_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_position = fpos_reg;
    assign element        = element_reg;
    assign last           = last_reg;
    assign entry_count    = ecount_reg;
    assign maximum        = maximum_reg;
    assign minimum        = minimum_reg;

    // The store never holds more than DEPTH entries
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    // The count only ever grows by one, and only on an insert
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) && ($past(cmd_reg) == CMD_INSERT))
        else $error("entry count changed outside an insert");

    // A full-store answer reports a full count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_FULL)) |-> (ecount_reg == DEPTH_C))
        else $error("full status with count below depth");

    // A hit position lies inside the used part of the store
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (fpos_reg != '0)) |->
            ((status_reg == ST_OK) && (fpos_reg <= ecount_reg)))
        else $error("found position outside the stored entries");

endmodule
